### src/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared widths and codes for the viscous stencil coefficient block.
// ----------------------------------------------------------------------------
package vsc_pkg;

  localparam int FRAC_W     = 17;
  localparam int REG_W      = 32;
  localparam int COEF_W     = 48;
  localparam int MAG_W      = COEF_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 32;
  localparam int QMUL_W     = 48;
  localparam int QMUL_LAT   = 2;
  localparam int FRAC_ONE   = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VISC_PHASE1 = 3'd0,
    REG_VISC_PHASE2 = 3'd1,
    REG_DENS_PHASE1 = 3'd2,
    REG_DENS_PHASE2 = 3'd3,
    REG_INV_DX      = 3'd4,
    REG_INV_DY      = 3'd5
  } cfg_reg_e;

endpackage

### src/vsc_if.sv
// ----------------------------------------------------------------------------
// vsc_if
// Valid/ready channels of the viscous stencil coefficient block.
// ----------------------------------------------------------------------------
interface vsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vsc_pkg::CFG_IDX_W-1:0]  index;
  logic [vsc_pkg::REG_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface vsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [vsc_pkg::FRAC_W-1:0]  frac_here;
  logic [vsc_pkg::FRAC_W-1:0]  frac_east;
  logic [vsc_pkg::FRAC_W-1:0]  frac_south_here;
  logic [vsc_pkg::FRAC_W-1:0]  frac_south_east;
  logic [vsc_pkg::FRAC_W-1:0]  frac_north_here;
  logic [vsc_pkg::FRAC_W-1:0]  frac_north_east;
  logic [vsc_pkg::FRAC_W-1:0]  aux_frac_here;
  logic [vsc_pkg::FRAC_W-1:0]  aux_frac_east;
  logic [vsc_pkg::FRAC_W-1:0]  solid_here;
  logic [vsc_pkg::FRAC_W-1:0]  solid_east;
  logic [vsc_pkg::FRAC_W-1:0]  moving_here;
  logic [vsc_pkg::FRAC_W-1:0]  moving_east;
  modport source (output valid, output frac_here, output frac_east, output frac_south_here,
                  output frac_south_east, output frac_north_here, output frac_north_east,
                  output aux_frac_here, output aux_frac_east, output solid_here,
                  output solid_east, output moving_here, output moving_east, input ready);
  modport sink   (input valid, input frac_here, input frac_east, input frac_south_here,
                  input frac_south_east, input frac_north_here, input frac_north_east,
                  input aux_frac_here, input aux_frac_east, input solid_here,
                  input solid_east, input moving_here, input moving_east, output ready);
endinterface

interface vsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_west;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_east;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_south;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_north;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_south_west;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_south_east;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_north_west;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_north_east;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_center_x;
  logic signed [vsc_pkg::COEF_W-1:0]  coef_center_y;
  modport source (output valid, output coef_west, output coef_east, output coef_south,
                  output coef_north, output coef_south_west, output coef_south_east,
                  output coef_north_west, output coef_north_east, output coef_center_x,
                  output coef_center_y, input ready);
  modport sink   (input valid, input coef_west, input coef_east, input coef_south,
                  input coef_north, input coef_south_west, input coef_south_east,
                  input coef_north_west, input coef_north_east, input coef_center_x,
                  input coef_center_y, output ready);
endinterface

### src/vsc_div.sv
// ----------------------------------------------------------------------------
// vsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vsc_div #(
  parameter int NUM_W = vsc_pkg::DIV_NUM_W,
  parameter int DEN_W = vsc_pkg::DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [NUM_W-1:0] num_p;
    logic [NUM_W-1:0] quo_p;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign den_p = den_i;
      assign num_p = num_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign num_p = num_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign trial = {rem_p, num_p[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[k] <= den_p;
        num_q[k] <= {num_p[NUM_W-2:0], 1'b0};
        quo_q[k] <= {quo_p[NUM_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[NUM_W-1];

endmodule

### src/vsc_qmul.sv
// ----------------------------------------------------------------------------
// vsc_qmul
// Two-stage Q16.16 product, (a*b)>>16, saturated to the coefficient magnitude.
// ----------------------------------------------------------------------------
module vsc_qmul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [vsc_pkg::QMUL_W-1:0] a_i,
  input  logic [vsc_pkg::QMUL_W-1:0] b_i,
  output logic [vsc_pkg::MAG_W-1:0]  p_o
);
  import vsc_pkg::*;

  localparam int H = QMUL_W / 2;

  logic [2*H-1:0]      pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [4*H-1:0]      sum;
  logic [4*H-17:0]     shifted;
  logic [MAG_W-1:0]    p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_hh_q <= a_i[2*H-1:H] * b_i[2*H-1:H];
      pp_hl_q <= a_i[2*H-1:H] * b_i[H-1:0];
      pp_lh_q <= a_i[H-1:0]   * b_i[2*H-1:H];
      pp_ll_q <= a_i[H-1:0]   * b_i[H-1:0];
    end
  end

  assign sum = {pp_hh_q, {(2*H){1'b0}}}
             + ({{(H-1){1'b0}}, ({1'b0, pp_hl_q} + {1'b0, pp_lh_q}), {H{1'b0}}})
             + {{(2*H){1'b0}}, pp_ll_q};
  assign shifted = sum[4*H-1:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (shifted > {{(4*H-16-MAG_W){1'b0}}, {MAG_W{1'b1}}}) ?
             {MAG_W{1'b1}} : shifted[MAG_W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

### src/viscous_stencil_coefficients.sv
// ----------------------------------------------------------------------------
// viscous_stencil_coefficients
// Ten viscous stencil coefficients for one x-velocity face.
// ----------------------------------------------------------------------------
// One face enters per clock unless the result side stalls or the sequencer
// is busy. Each face passes the 48-stage pipelined dividers that form the
// harmonic viscosities and the fluid weight, then three two-stage Q16.16
// product steps. A stall on the result side holds the whole pipeline. After
// each register write a serial divider recomputes nu1, mu1/mu2 and ro2/ro1,
// one bit a cycle; no face is taken until it is done.
module viscous_stencil_coefficients (
  input  logic        clk_i,
  input  logic        rst_ni,
  vsc_cfg_if.sink     cfg_i,
  vsc_in_if.sink      item_i,
  vsc_out_if.source   coef_o
);
  import vsc_pkg::*;

  localparam int LAT    = 2 + DIV_NUM_W + 3 * QMUL_LAT + 1;
  localparam int RX_DLY = 2 * QMUL_LAT;
  localparam int CNT_W  = $clog2(DIV_NUM_W);
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_STORE = 4'b1000
  } seq_state_e;

  typedef enum logic [1:0] {
    OP_NU1   = 2'd0,
    OP_RATIO = 2'd1,
    OP_RHO   = 2'd2
  } seq_op_e;

  function automatic logic [FRAC_W-1:0] frac_sat(logic [FRAC_W-1:0] v);
    return (v > FRAC_W'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE) : v;
  endfunction

  function automatic logic [15:0] frac_clamp(logic [17:0] v);
    if (v == 18'd0) return 16'd1;
    if (v > 18'd65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [REG_W-1:0] nz(logic [REG_W-1:0] v);
    return (v == '0) ? REG_W'(1) : v;
  endfunction

  // ((1-a)*1 + a*r) in Q16.16, never zero
  function automatic logic [REG_W-1:0] mix_den(logic [FRAC_W-1:0] a, logic [REG_W-1:0] r);
    logic [48:0] p;
    logic [49:0] t;
    p = a * r;
    t = {1'b0, p} + {17'd0, (FRAC_W'(FRAC_ONE) - a), 16'd0};
    return nz(t[47:16]);
  endfunction

  // --------------------------------------------------------------------------
  // registers and derived constants
  // --------------------------------------------------------------------------
  logic [REG_W-1:0] visc1_q, visc2_q, dens1_q, dens2_q, inv_dx_q, inv_dy_q;
  logic [REG_W-1:0] nu1_q, ratio_q, rho_q;
  seq_state_e       state_q;
  seq_op_e          op_q;
  logic [DIV_NUM_W-1:0] sq_num_q, sq_quo_q;
  logic [DIV_DEN_W-1:0] sq_rem_q, sq_den_q;
  logic [CNT_W-1:0]     sq_cnt_q;
  logic [REG_W-1:0]     sel_num, sel_den;
  logic [DIV_DEN_W:0]   sq_trial, sq_diff;
  logic                 sq_ge;
  logic                 seq_idle;

  always_comb begin
    case (op_q)
      OP_NU1:   begin sel_num = visc1_q; sel_den = dens1_q; end
      OP_RATIO: begin sel_num = visc1_q; sel_den = visc2_q; end
      OP_RHO:   begin sel_num = dens2_q; sel_den = dens1_q; end
      default:  begin sel_num = visc1_q; sel_den = dens1_q; end
    endcase
  end

  assign sq_trial = {sq_rem_q, sq_num_q[DIV_NUM_W-1]};
  assign sq_ge    = sq_trial >= {1'b0, sq_den_q};
  assign sq_diff  = sq_trial - {1'b0, sq_den_q};
  assign seq_idle = (state_q == ST_IDLE);
  assign cfg_i.ready = seq_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc1_q  <= REG_W'(FRAC_ONE);
      visc2_q  <= REG_W'(FRAC_ONE);
      dens1_q  <= REG_W'(FRAC_ONE);
      dens2_q  <= REG_W'(FRAC_ONE);
      inv_dx_q <= REG_W'(FRAC_ONE);
      inv_dy_q <= REG_W'(FRAC_ONE);
      nu1_q    <= REG_W'(FRAC_ONE);
      ratio_q  <= REG_W'(FRAC_ONE);
      rho_q    <= REG_W'(FRAC_ONE);
      state_q  <= ST_IDLE;
      op_q     <= OP_NU1;
      sq_num_q <= '0;
      sq_quo_q <= '0;
      sq_rem_q <= '0;
      sq_den_q <= '0;
      sq_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cfg_i.valid) begin
            case (cfg_reg_e'(cfg_i.index))
              REG_VISC_PHASE1: visc1_q  <= cfg_i.data;
              REG_VISC_PHASE2: visc2_q  <= cfg_i.data;
              REG_DENS_PHASE1: dens1_q  <= cfg_i.data;
              REG_DENS_PHASE2: dens2_q  <= cfg_i.data;
              REG_INV_DX:      inv_dx_q <= cfg_i.data;
              REG_INV_DY:      inv_dy_q <= cfg_i.data;
              default: ;
            endcase
            op_q    <= OP_NU1;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          sq_num_q <= {sel_num, 16'd0};
          sq_den_q <= nz(sel_den);
          sq_rem_q <= '0;
          sq_quo_q <= '0;
          sq_cnt_q <= '0;
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          sq_rem_q <= sq_ge ? sq_diff[DIV_DEN_W-1:0] : sq_trial[DIV_DEN_W-1:0];
          sq_num_q <= {sq_num_q[DIV_NUM_W-2:0], 1'b0};
          sq_quo_q <= {sq_quo_q[DIV_NUM_W-2:0], sq_ge};
          sq_cnt_q <= sq_cnt_q + 1'b1;
          if (sq_cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          // quotient saturates to 32 bits
          case (op_q)
            OP_NU1: begin
              nu1_q   <= (sq_quo_q[DIV_NUM_W-1:REG_W] != '0) ? '1 : sq_quo_q[REG_W-1:0];
              op_q    <= OP_RATIO;
              state_q <= ST_LOAD;
            end
            OP_RATIO: begin
              ratio_q <= (sq_quo_q[DIV_NUM_W-1:REG_W] != '0) ? '1 : sq_quo_q[REG_W-1:0];
              op_q    <= OP_RHO;
              state_q <= ST_LOAD;
            end
            default: begin
              rho_q   <= (sq_quo_q[DIV_NUM_W-1:REG_W] != '0) ? '1 : sq_quo_q[REG_W-1:0];
              state_q <= ST_IDLE;
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: every stage advances together
  // --------------------------------------------------------------------------
  logic [LAT-1:0] vld_q;
  logic           en;

  assign en           = !vld_q[LAT-1] || coef_o.ready;
  assign item_i.ready = en && seq_idle;
  assign coef_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], item_i.valid && seq_idle};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: face and corner averages, clamped fractions
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0] f_here, f_east, f_sh, f_se, f_nh, f_ne, f_ah, f_ae;
  logic [FRAC_W-1:0] f_sol_h, f_sol_e, f_mov_h, f_mov_e;
  logic [18:0]       sum_s, sum_n, sum_ph, sum_pw;
  logic [FRAC_W-1:0] a_q [4];
  logic [15:0]       ph_q, pw_q;

  always_comb begin
    f_here  = frac_sat(item_i.frac_here);
    f_east  = frac_sat(item_i.frac_east);
    f_sh    = frac_sat(item_i.frac_south_here);
    f_se    = frac_sat(item_i.frac_south_east);
    f_nh    = frac_sat(item_i.frac_north_here);
    f_ne    = frac_sat(item_i.frac_north_east);
    f_ah    = frac_sat(item_i.aux_frac_here);
    f_ae    = frac_sat(item_i.aux_frac_east);
    f_sol_h = frac_sat(item_i.solid_here);
    f_sol_e = frac_sat(item_i.solid_east);
    f_mov_h = frac_sat(item_i.moving_here);
    f_mov_e = frac_sat(item_i.moving_east);
    sum_s   = 19'(f_here) + 19'(f_east) + 19'(f_sh) + 19'(f_se);
    sum_n   = 19'(f_here) + 19'(f_east) + 19'(f_nh) + 19'(f_ne);
    sum_ph  = 19'(f_ah) + 19'(f_ae) + 19'(f_here) + 19'(f_east);
    sum_pw  = 19'(f_sol_h) + 19'(f_sol_e) + 19'(f_mov_h) + 19'(f_mov_e);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= f_here;
      a_q[1] <= f_east;
      a_q[2] <= sum_s[18:2];
      a_q[3] <= sum_n[18:2];
      ph_q   <= frac_clamp({1'b0, sum_ph[18:2]});
      pw_q   <= frac_clamp(sum_pw[18:1]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: harmonic denominators and relative density
  // --------------------------------------------------------------------------
  logic [REG_W-1:0] den_q [4];
  logic [REG_W-1:0] ro_q;
  logic [15:0]      onem_pw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        den_q[k] <= mix_den(a_q[k], ratio_q);
      end
      ro_q      <= mix_den({1'b0, ph_q}, rho_q);
      onem_pw_q <= 16'(FRAC_W'(FRAC_ONE) - {1'b0, pw_q});
    end
  end

  // --------------------------------------------------------------------------
  // dividers: four viscosities and the fluid weight
  // --------------------------------------------------------------------------
  logic [DIV_NUM_W-1:0] rx [4];
  logic [DIV_NUM_W-1:0] cf;

  for (genvar k = 0; k < 4; k++) begin : g_visc
    vsc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({nu1_q, 16'd0}),
      .den_i (den_q[k]),
      .quo_o (rx[k])
    );
  end

  vsc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_cf (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({16'd0, onem_pw_q, 16'd0}),
    .den_i (ro_q),
    .quo_o (cf)
  );

  // viscosities wait for the two weight products
  logic [DIV_NUM_W-1:0] rx_q [RX_DLY][4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rx_q[0][k] <= rx[k];
        for (int d = 1; d < RX_DLY; d++) begin
          rx_q[d][k] <= rx_q[d-1][k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // products: weight times spacings, then times viscosities
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] u_x, u_y, kxx, kyy, kxy;
  logic [MAG_W-1:0] w0, e0, s0, n0, sw0, nw0;

  vsc_qmul u_m_cx (.clk_i, .en_i(en), .a_i(cf), .b_i({16'd0, inv_dx_q}), .p_o(u_x));
  vsc_qmul u_m_cy (.clk_i, .en_i(en), .a_i(cf), .b_i({16'd0, inv_dy_q}), .p_o(u_y));

  vsc_qmul u_m_kxx (.clk_i, .en_i(en), .a_i({1'b0, u_x}), .b_i({16'd0, inv_dx_q}), .p_o(kxx));
  vsc_qmul u_m_kyy (.clk_i, .en_i(en), .a_i({1'b0, u_y}), .b_i({16'd0, inv_dy_q}), .p_o(kyy));
  vsc_qmul u_m_kxy (.clk_i, .en_i(en), .a_i({1'b0, u_x}), .b_i({16'd0, inv_dy_q}), .p_o(kxy));

  vsc_qmul u_m_w  (.clk_i, .en_i(en), .a_i({1'b0, kxx}), .b_i(rx_q[RX_DLY-1][0]), .p_o(w0));
  vsc_qmul u_m_e  (.clk_i, .en_i(en), .a_i({1'b0, kxx}), .b_i(rx_q[RX_DLY-1][1]), .p_o(e0));
  vsc_qmul u_m_s  (.clk_i, .en_i(en), .a_i({1'b0, kyy}), .b_i(rx_q[RX_DLY-1][2]), .p_o(s0));
  vsc_qmul u_m_n  (.clk_i, .en_i(en), .a_i({1'b0, kyy}), .b_i(rx_q[RX_DLY-1][3]), .p_o(n0));
  vsc_qmul u_m_sw (.clk_i, .en_i(en), .a_i({1'b0, kxy}), .b_i(rx_q[RX_DLY-1][2]), .p_o(sw0));
  vsc_qmul u_m_nw (.clk_i, .en_i(en), .a_i({1'b0, kxy}), .b_i(rx_q[RX_DLY-1][3]), .p_o(nw0));

  // --------------------------------------------------------------------------
  // final stage: doubling, centre sums, signs
  // --------------------------------------------------------------------------
  logic [MAG_W:0]   w_sum, e_sum, cx_sum, cy_sum;
  logic [MAG_W-1:0] w_sat, e_sat, cx_sat, cy_sat;
  logic [COEF_W-1:0] west_q, east_q, south_q, north_q, sw_q, se_q, nw_q, ne_q, cx_q, cy_q;

  always_comb begin
    w_sum  = {1'b0, w0} + {1'b0, w0};
    w_sat  = w_sum[MAG_W] ? MAG_MAX : w_sum[MAG_W-1:0];
    e_sum  = {1'b0, e0} + {1'b0, e0};
    e_sat  = e_sum[MAG_W] ? MAG_MAX : e_sum[MAG_W-1:0];
    cx_sum = {1'b0, w_sat} + {1'b0, e_sat};
    cx_sat = cx_sum[MAG_W] ? MAG_MAX : cx_sum[MAG_W-1:0];
    cy_sum = {1'b0, s0} + {1'b0, n0};
    cy_sat = cy_sum[MAG_W] ? MAG_MAX : cy_sum[MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      west_q  <= {1'b0, w_sat};
      east_q  <= {1'b0, e_sat};
      south_q <= {1'b0, s0};
      north_q <= {1'b0, n0};
      sw_q    <= {1'b0, sw0};
      se_q    <= -{1'b0, sw0};
      nw_q    <= -{1'b0, nw0};
      ne_q    <= {1'b0, nw0};
      cx_q    <= -{1'b0, cx_sat};
      cy_q    <= -{1'b0, cy_sat};
    end
  end

  assign coef_o.coef_west       = west_q;
  assign coef_o.coef_east       = east_q;
  assign coef_o.coef_south      = south_q;
  assign coef_o.coef_north      = north_q;
  assign coef_o.coef_south_west = sw_q;
  assign coef_o.coef_south_east = se_q;
  assign coef_o.coef_north_west = nw_q;
  assign coef_o.coef_north_east = ne_q;
  assign coef_o.coef_center_x   = cx_q;
  assign coef_o.coef_center_y   = cy_q;

endmodule

### src/vsc_checker.sv
// ----------------------------------------------------------------------------
// vsc_checker
// Port-level checks for the viscous stencil coefficient block.
// ----------------------------------------------------------------------------
module vsc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_ready_i,
  input logic                              item_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [vsc_pkg::COEF_W-1:0] coef_south_west_i,
  input logic signed [vsc_pkg::COEF_W-1:0] coef_south_east_i,
  input logic signed [vsc_pkg::COEF_W-1:0] coef_north_west_i,
  input logic signed [vsc_pkg::COEF_W-1:0] coef_north_east_i
);

  // a result waiting for transfer stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // no face taken while derived constants are being recomputed
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_i |-> !item_ready_i)
    else $error("item accepted during constant update");

  a_south_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> coef_south_east_i == -coef_south_west_i)
    else $error("south cross pair mismatch");

  a_north_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> coef_north_west_i == -coef_north_east_i)
    else $error("north cross pair mismatch");

endmodule

bind viscous_stencil_coefficients vsc_checker u_vsc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_ready_i       (cfg_i.ready),
  .item_ready_i      (item_i.ready),
  .out_valid_i       (coef_o.valid),
  .out_ready_i       (coef_o.ready),
  .coef_south_west_i (coef_o.coef_south_west),
  .coef_south_east_i (coef_o.coef_south_east),
  .coef_north_west_i (coef_o.coef_north_west),
  .coef_north_east_i (coef_o.coef_north_east)
);
